// ===== rtl/mexp_pkg.sv =====
// Shared constants, types and helpers for the modular exponent unit.
package mexp_pkg;

    localparam int unsigned OP_W  = 1;
    localparam int unsigned EXP_W = 63;
    localparam int unsigned RES_W = 30;
    localparam int unsigned CNT_W = 6;

    localparam logic [RES_W-1:0] PRIME      = 30'd1000000007;
    localparam logic [RES_W-1:0] FERMAT_EXP = 30'd1000000005;
    localparam logic [RES_W+1:0] PRIME_X1   = 32'd1000000007;
    localparam logic [RES_W+1:0] PRIME_X2   = 32'd2000000014;

    localparam logic [OP_W-1:0] OP_POWER   = 1'b0;
    localparam logic [OP_W-1:0] OP_INVERSE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_ISSUE,
        ST_WAIT,
        ST_DONE
    } state_t;

    // One word travelling along the multiplier row: two products share the multiplier b.
    typedef struct packed {
        logic             v;
        logic [RES_W-1:0] p_sq;
        logic [RES_W-1:0] p_mul;
        logic [RES_W-1:0] a_sq;
        logic [RES_W-1:0] a_mul;
        logic [RES_W-1:0] b;
    } cell_t;

    // Brings a value below three times the prime back into range.
    function automatic logic [RES_W-1:0] mod_fix(input logic [RES_W+1:0] x);
        logic [RES_W+1:0] y;
        begin
            if (x >= PRIME_X2)
                y = x - PRIME_X2;
            else if (x >= PRIME_X1)
                y = x - PRIME_X1;
            else
                y = x;
            return y[RES_W-1:0];
        end
    endfunction

endpackage

// ===== rtl/mexp_cell.sv =====
// One cell of the interleaved modular multiplier row: handles one multiplier bit.
module mexp_cell
    import mexp_pkg::*;
#(
    parameter int unsigned BIT = 0
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  cell_t din,
    output cell_t dout
);

    cell_t            dout_reg;
    cell_t            dout_next;
    logic [RES_W+1:0] sum_sq;
    logic [RES_W+1:0] sum_mul;
    logic             bit_set;

    always_comb
    begin
        bit_set = din.b[BIT];
        sum_sq  = {1'b0, din.p_sq, 1'b0}  + (bit_set ? {2'b00, din.a_sq}  : '0);
        sum_mul = {1'b0, din.p_mul, 1'b0} + (bit_set ? {2'b00, din.a_mul} : '0);
        dout_next       = din;
        dout_next.p_sq  = mod_fix(sum_sq);
        dout_next.p_mul = mod_fix(sum_mul);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dout_reg <= '0;
        else
            dout_reg <= dout_next;
    end

    assign dout = dout_reg;

endmodule

// ===== rtl/mexp_chain.sv =====
// Row of multiplier cells, most significant multiplier bit first.
module mexp_chain
    import mexp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cell_t din,
    output cell_t dout
);

    cell_t link [RES_W+1];

    assign link[0] = din;

    for (genvar k = 0; k < RES_W; k++)
    begin : g_cell
        mexp_cell #(
            .BIT (RES_W - 1 - k)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .din   (link[k]),
            .dout  (link[k+1])
        );
    end

    assign dout = link[RES_W];

endmodule

// ===== rtl/modular_exponent_unit_core.sv =====
// Modular exponentiation modulo 1000000007, right-to-left square and multiply.
// The base is first reduced below the prime, one bit a cycle over all 63 bits; then each
// exponent bit up to the highest set bit takes one pass through the 30-cell multiplier row;
// the inverse uses a 30-bit exponent. An exponent of zero skips the passes.
// Throughput: one word at a time; the next word is taken once the result is delivered.
// Reset: rst_n clears the controller and the cell valid bits; the unit comes up idle.
module modular_exponent_unit_core
    import mexp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [OP_W-1:0]  operation,
    input  logic [EXP_W-1:0] base_value,
    input  logic [EXP_W-1:0] exponent,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [RES_W-1:0] result
);

    state_t           state_reg, state_next;
    logic [EXP_W-1:0] base_reg, base_next;
    logic [EXP_W-1:0] exp_reg, exp_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [RES_W-1:0] sq_reg, sq_next;
    logic [RES_W-1:0] acc_reg, acc_next;
    logic [RES_W:0]   shifted;
    cell_t            chain_in;
    cell_t            chain_out;

    mexp_chain u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .din   (chain_in),
        .dout  (chain_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        exp_reg  <= exp_next;
        cnt_reg  <= cnt_next;
        sq_reg   <= sq_next;
        acc_reg  <= acc_next;
    end

    always_comb
    begin
        state_next = state_reg;
        base_next  = base_reg;
        exp_next   = exp_reg;
        cnt_next   = cnt_reg;
        sq_next    = sq_reg;
        acc_next   = acc_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        shifted    = {sq_reg, base_reg[cnt_reg]};
        chain_in         = '0;
        chain_in.a_sq    = sq_reg;
        chain_in.a_mul   = acc_reg;
        chain_in.b       = sq_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    base_next  = base_value;
                    exp_next   = (operation == OP_INVERSE)
                                 ? {{(EXP_W-RES_W){1'b0}}, FERMAT_EXP} : exponent;
                    cnt_next   = CNT_W'(EXP_W - 1);
                    sq_next    = '0;
                    acc_next   = RES_W'(1);
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                // Shift in one base bit; the partial remainder stays below the prime.
                if (shifted >= {1'b0, PRIME})
                    shifted = shifted - {1'b0, PRIME};
                sq_next = shifted[RES_W-1:0];
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                    state_next = ST_ISSUE;
            end
            ST_ISSUE:
            begin
                if (exp_reg == '0)
                    state_next = ST_DONE;
                else
                begin
                    chain_in.v = 1'b1;
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (chain_out.v)
                begin
                    sq_next = chain_out.p_sq;
                    if (exp_reg[0])
                        acc_next = chain_out.p_mul;
                    exp_next   = exp_reg >> 1;
                    state_next = ST_ISSUE;
                end
            end
            ST_DONE:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign result = acc_reg;

endmodule

// ===== rtl/mexp_checker.sv =====
// Port-level checks for the modular exponent unit, bound to the top level.
module mexp_checker
    import mexp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_ready,
    input  logic             out_valid,
    input  logic             out_ready,
    input  logic [RES_W-1:0] result
);

    // A finished word holds until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result))
        else $error("result word changed or dropped while stalled");

    // Results are always reduced.
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> result < PRIME)
        else $error("result not below the prime");

    // The unit never takes a word while a result is pending.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while a result is pending");

    // A result cannot appear the cycle after a word is taken.
    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !out_valid && !in_ready)
        else $error("result appeared without any work");

endmodule

bind modular_exponent_unit_core mexp_checker u_mexp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result)
);

// ===== tb/sv/mexp_checker.sv =====
// Result checker for the modular exponent unit: watches both channels and compares results.
`timescale 1ns / 100ps
module mexp_scoreboard
    import mexp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_ready,
    input  logic [OP_W-1:0]  operation,
    input  logic [EXP_W-1:0] base_value,
    input  logic [EXP_W-1:0] exponent,
    input  logic             out_valid,
    input  logic             out_ready,
    input  logic [RES_W-1:0] result,
    output int               fail_count,
    output int               pending
);

    logic [RES_W-1:0] expected_powers[$];

    // Right-to-left square and multiply modulo the prime.
    function automatic logic [RES_W-1:0] predict_power(input logic [OP_W-1:0] op,
                                                       input logic [EXP_W-1:0] b,
                                                       input logic [EXP_W-1:0] e);
        logic [63:0] acc;
        logic [63:0] sq;
        logic [63:0] ee;
        begin
            acc = 64'd1;
            sq = {1'b0, b} % 64'd1000000007;
            ee = (op == OP_INVERSE) ? 64'd1000000005 : {1'b0, e};
            while (ee != 0)
            begin
                if (ee[0])
                    acc = (acc * sq) % 64'd1000000007;
                sq = (sq * sq) % 64'd1000000007;
                ee = ee >> 1;
            end
            return acc[RES_W-1:0];
        end
    endfunction

    assign pending = expected_powers.size();

    initial fail_count = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_powers.size() == 0)
                begin
                    $error("result word with nothing expected: result=%0d", result);
                    fail_count <= fail_count + 1;
                end
                else if (result !== expected_powers[0])
                begin
                    $error("result mismatch: expected %0d, actual %0d",
                           expected_powers[0], result);
                    fail_count <= fail_count + 1;
                    void'(expected_powers.pop_front());
                end
                else
                    void'(expected_powers.pop_front());
            end
            if (in_valid && in_ready)
                expected_powers.insert(expected_powers.size(),
                                       predict_power(operation, base_value, exponent));
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// Top of the modular exponent unit testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module tb_top;
    import mexp_pkg::*;

    localparam longint CYCLE_LIMIT = 64'd20000000;
    localparam int     RANDOM_WORDS = 1500;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    logic [OP_W-1:0]  operation = OP_POWER;
    logic [EXP_W-1:0] base_value = '0;
    logic [EXP_W-1:0] exponent = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [RES_W-1:0] result;
    int               fail_count;
    int               pending;
    int               send_idle_pct = 0;
    int               recv_stall_pct = 0;
    longint           cycle_count = 0;

    always #2 clk = ~clk;

    modular_exponent_unit_core u_top (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .base_value(base_value), .exponent(exponent),
        .out_valid(out_valid), .out_ready(out_ready), .result(result)
    );

    mexp_scoreboard u_checker (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .operation(operation), .base_value(base_value), .exponent(exponent),
        .out_valid(out_valid), .out_ready(out_ready), .result(result),
        .fail_count(fail_count), .pending(pending)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("modular_exponent_unit_core regression: fail");
            $finish;
        end
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    function automatic logic [EXP_W-1:0] random_wide();
        logic [63:0] w;
        begin
            w = {$urandom(), $urandom()};
            return w[EXP_W-1:0];
        end
    endfunction

    // Drives one word and holds it until the handshake takes it.
    task automatic send_word(input logic [OP_W-1:0] op, input logic [EXP_W-1:0] b,
                             input logic [EXP_W-1:0] e);
        begin
            while ($urandom_range(99) < send_idle_pct)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            in_valid <= 1'b1;
            operation <= op;
            base_value <= b;
            exponent <= e;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            @(negedge clk);
        end
    endtask

    // Short exponents mostly, since the pass count follows the top set bit.
    task automatic send_random();
        logic [EXP_W-1:0] b;
        logic [EXP_W-1:0] e;
        int               kind;
        begin
            kind = $urandom_range(9);
            b = random_wide() >> $urandom_range(62);
            if ($urandom_range(9) == 0)
                b = 63'd1000000007 * $urandom_range(1000);
            e = random_wide() >> (kind == 0 ? 0 : $urandom_range(62, 40));
            send_word(kind == 1 ? OP_INVERSE : OP_POWER, b, e);
        end
    endtask

    initial
    begin
        int phase;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed words: field extremes, zero exponent, zero base, multiples of the prime.
        send_word(OP_POWER, '0, '0);
        send_word(OP_POWER, '0, 63'd5);
        send_word(OP_POWER, 63'd1000000007, '0);
        send_word(OP_POWER, 63'd1000000007, 63'd3);
        send_word(OP_POWER, '1, '1);
        send_word(OP_POWER, '1, 63'd1);
        send_word(OP_POWER, 63'd2, 63'd62);
        send_word(OP_POWER, 63'd1000000006, 63'd2);
        send_word(OP_POWER, 63'd1000000008, 63'd1000000006);
        send_word(OP_INVERSE, '0, '1);
        send_word(OP_INVERSE, 63'd1, '0);
        send_word(OP_INVERSE, 63'd2, 63'd7);
        send_word(OP_INVERSE, '1, '1);
        send_word(OP_INVERSE, 63'd2000000014, 63'd9);
        send_word(OP_INVERSE, 63'd1000000006, '0);
        in_valid <= 1'b0;

        // Let the unit drain completely before the random part.
        while (pending != 0)
            @(negedge clk);

        for (phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
                3: begin send_idle_pct = 19; recv_stall_pct = 19; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            repeat (RANDOM_WORDS / 5)
                send_random();
        end
        in_valid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (2000) @(negedge clk);

        if (fail_count == 0 && pending == 0)
            $display("modular_exponent_unit_core regression: pass");
        else
            $display("modular_exponent_unit_core regression: fail");
        $finish;
    end

endmodule
